// ----- design/ipmc_pkg.sv -----
`default_nettype none
package ipmc_pkg;

  localparam int SYM_W = 31;
  localparam int CNT_W = 32;
  localparam int LEN_W = 5;
  localparam int POS_W = 4;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_TEXT = 1'b1;

  typedef logic [SYM_W-1:0] sym_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // status from the gcd unit back to the sequencer
  typedef struct packed {
    logic done;
    logic common;
  } gcd_res_t;

endpackage
`default_nettype wire

// ----- design/ipmc_ram.sv -----
`default_nettype none
module ipmc_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- design/ipmc_gcd.sv -----
`default_nettype none
module ipmc_gcd
  import ipmc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  input  wire sym_t a_in,
  input  wire sym_t b_in,
  output gcd_res_t  res
);

  typedef enum logic {G_IDLE, G_RUN} gstate_t;

  gstate_t state_r, state_nxt;
  sym_t    a_r, a_nxt;
  sym_t    b_r, b_nxt;
  logic    done_r, done_nxt;
  logic    common_r, common_nxt;

  // binary gcd, one shift or one subtract per cycle; only gcd > 1 is needed
  always_comb begin
    state_nxt  = state_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    done_nxt   = 1'b0;
    common_nxt = common_r;
    unique case (state_r)
      G_IDLE: begin
        if (start) begin
          a_nxt     = a_in;
          b_nxt     = b_in;
          state_nxt = G_RUN;
        end
      end
      G_RUN: begin
        if (a_r == '0) begin
          common_nxt = (b_r > sym_t'(1));
          done_nxt   = 1'b1;
          state_nxt  = G_IDLE;
        end else if (b_r == '0) begin
          common_nxt = (a_r > sym_t'(1));
          done_nxt   = 1'b1;
          state_nxt  = G_IDLE;
        end else if (!a_r[0] && !b_r[0]) begin
          common_nxt = 1'b1;
          done_nxt   = 1'b1;
          state_nxt  = G_IDLE;
        end else if (!a_r[0]) begin
          a_nxt = a_r >> 1;
        end else if (!b_r[0]) begin
          b_nxt = b_r >> 1;
        end else if (a_r == b_r) begin
          common_nxt = (a_r != sym_t'(1));
          done_nxt   = 1'b1;
          state_nxt  = G_IDLE;
        end else if (a_r > b_r) begin
          a_nxt = a_r - b_r;
        end else begin
          b_nxt = b_r - a_r;
        end
      end
      default: state_nxt = G_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= G_IDLE;
      done_r   <= 1'b0;
      common_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      done_r   <= done_nxt;
      common_r <= common_nxt;
    end
    a_r <= a_nxt;
    b_r <= b_nxt;
  end

  assign res.done   = done_r;
  assign res.common = common_r;

endmodule
`default_nettype wire

// ----- design/indeterminate_pattern_match_counter.sv -----
`default_nettype none
// channel  direction  handshake           words
// in_      input      in_valid/in_stall   func, position, symbol, last
// out_     output     out_valid/out_stall match_here, occurrences, final_res
// cfg_     input      cfg_valid/cfg_ready pattern length
//
// a pattern load passes through S_EMIT and registers its result once the output is free
// a text word visits, per pattern entry, S_READ for the store read, S_START for the gcd
// start and S_GCD for the gcd run, then S_FIN and S_EMIT; an entry whose preceding
// partial bit is clear skips its gcd
// reset clears the partial bits and the count and sets the length to 1, not the store
// a held result does not block acceptance of the next word
module indeterminate_pattern_match_counter
  import ipmc_pkg::*;
#(
  parameter int PATTERN_MAX = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic             in_func,
  input  wire logic [POS_W-1:0] in_position,
  input  wire logic [SYM_W-1:0] in_symbol,
  input  wire logic             in_last,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic                  out_match_here,
  output logic      [CNT_W-1:0] out_occurrences,
  output logic                  out_final_res,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [LEN_W-1:0] cfg_data
);

  localparam int IW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

  typedef enum logic [2:0] {S_IDLE, S_READ, S_START, S_GCD, S_FIN, S_EMIT} state_t;

  state_t                 state_r, state_nxt;
  logic [IW-1:0]          idx_r, idx_nxt;
  sym_t                   sym_r, sym_nxt;
  logic                   last_r, last_nxt;
  logic [PATTERN_MAX-1:0] bits_r, bits_nxt;
  logic [PATTERN_MAX-1:0] nbits_r, nbits_nxt;
  cnt_t                   count_r, count_nxt;
  logic [LEN_W-1:0]       len_r, len_nxt;
  logic                   res_match_r, res_match_nxt;
  cnt_t                   res_count_r, res_count_nxt;
  logic                   res_final_r, res_final_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_match_r, out_match_nxt;
  cnt_t                   out_count_r, out_count_nxt;
  logic                   out_final_r, out_final_nxt;

  logic                   ram_we;
  logic [IW-1:0]          ram_waddr;
  sym_t                   ram_rdata;
  logic                   gcd_start;
  gcd_res_t               gcd_res;

  logic                   in_acc;
  logic                   out_free;
  logic                   prev_bit;
  logic                   idx_end;
  logic [8:0]             len_sel;
  logic [IW-1:0]          hit_idx;
  logic                   hit;
  cnt_t                   count_inc;

  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign idx_end   = (idx_r == IW'(PATTERN_MAX - 1));
  assign prev_bit  = (idx_r == '0) ? 1'b1 : bits_r[idx_r - IW'(1)];
  assign ram_waddr = IW'(in_position);

  always_comb begin
    if (len_r == '0) begin
      len_sel = 9'd1;
    end else if (9'(len_r) > 9'(PATTERN_MAX)) begin
      len_sel = 9'(PATTERN_MAX);
    end else begin
      len_sel = 9'(len_r);
    end
  end

  assign hit_idx   = IW'(len_sel - 9'd1);
  assign hit       = nbits_r[hit_idx];
  assign count_inc = (hit && (count_r != '1)) ? count_r + cnt_t'(1) : count_r;

  ipmc_ram #(
    .WIDTH (SYM_W),
    .DEPTH (PATTERN_MAX),
    .AW    (IW)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_symbol),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  ipmc_gcd u_gcd (
    .clk   (clk),
    .rst_n (rst_n),
    .start (gcd_start),
    .a_in  (sym_r),
    .b_in  (ram_rdata),
    .res   (gcd_res)
  );

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    sym_nxt       = sym_r;
    last_nxt      = last_r;
    bits_nxt      = bits_r;
    nbits_nxt     = nbits_r;
    count_nxt     = count_r;
    len_nxt       = len_r;
    res_match_nxt = res_match_r;
    res_count_nxt = res_count_r;
    res_final_nxt = res_final_r;
    out_valid_nxt = out_valid_r;
    out_match_nxt = out_match_r;
    out_count_nxt = out_count_r;
    out_final_nxt = out_final_r;
    ram_we        = 1'b0;
    gcd_start     = 1'b0;

    if (cfg_valid) begin
      len_nxt = cfg_data;
    end
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          sym_nxt  = in_symbol;
          last_nxt = in_last;
          if (in_func == FUNC_LOAD) begin
            ram_we        = (9'(in_position) < 9'(PATTERN_MAX));
            res_match_nxt = 1'b0;
            res_count_nxt = count_r;
            res_final_nxt = 1'b0;
            state_nxt     = S_EMIT;
          end else begin
            idx_nxt   = '0;
            state_nxt = S_READ;
          end
        end
      end
      S_READ: begin
        state_nxt = S_START;
      end
      S_START: begin
        if (!prev_bit) begin
          nbits_nxt[idx_r] = 1'b0;
          if (idx_end) begin
            state_nxt = S_FIN;
          end else begin
            idx_nxt   = idx_r + IW'(1);
            state_nxt = S_READ;
          end
        end else begin
          gcd_start = 1'b1;
          state_nxt = S_GCD;
        end
      end
      S_GCD: begin
        if (gcd_res.done) begin
          nbits_nxt[idx_r] = gcd_res.common;
          if (idx_end) begin
            state_nxt = S_FIN;
          end else begin
            idx_nxt   = idx_r + IW'(1);
            state_nxt = S_READ;
          end
        end
      end
      S_FIN: begin
        res_match_nxt = hit;
        res_count_nxt = count_inc;
        res_final_nxt = last_r;
        if (last_r) begin
          bits_nxt  = '0;
          nbits_nxt = '0;
          count_nxt = '0;
        end else begin
          bits_nxt  = nbits_r;
          count_nxt = count_inc;
        end
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_match_nxt = res_match_r;
          out_count_nxt = res_count_r;
          out_final_nxt = res_final_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      bits_r      <= '0;
      nbits_r     <= '0;
      count_r     <= '0;
      len_r       <= LEN_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bits_r      <= bits_nxt;
      nbits_r     <= nbits_nxt;
      count_r     <= count_nxt;
      len_r       <= len_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r       <= idx_nxt;
    sym_r       <= sym_nxt;
    last_r      <= last_nxt;
    res_match_r <= res_match_nxt;
    res_count_r <= res_count_nxt;
    res_final_r <= res_final_nxt;
    out_match_r <= out_match_nxt;
    out_count_r <= out_count_nxt;
    out_final_r <= out_final_nxt;
  end

  assign in_stall        = (state_r != S_IDLE);
  assign cfg_ready       = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_match_here  = out_match_r;
  assign out_occurrences = out_count_r;
  assign out_final_res   = out_final_r;

  a_rose_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EMIT))
    else $error("result word appeared outside emit");

  a_match_counts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_match_r |-> out_count_r != '0)
    else $error("match reported with zero count");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r != S_IDLE)
    else $error("accepted word left no work in flight");

endmodule
`default_nettype wire
